// ===== sv/jsu_pkg.sv =====
// Shared types and constants for the Jacobi symbol unit.
package jsu_pkg;

  localparam int MOD_W       = 31;
  localparam int REM_W       = MOD_W + 1;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [MOD_W-1:0] mod_t;
  typedef logic signed [1:0] sym_t;

  localparam sym_t SYM_ZERO = 2'sb00;
  localparam sym_t SYM_POS  = 2'sb01;
  localparam sym_t SYM_NEG  = 2'sb11;

  // Header of a queued item; the value magnitude travels next to it.
  typedef struct packed {
    logic bad;
    logic neg;
    mod_t modulus;
  } item_hdr_t;

  localparam int HDR_W = $bits(item_hdr_t);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RED  = 5'b00010,
    ST_FIX  = 5'b00100,
    ST_LOOP = 5'b01000,
    ST_DONE = 5'b10000
  } back_state_t;

endpackage

// ===== sv/jsu_front.sv =====
// Front end: takes items, splits sign and magnitude, flags an even modulus.
module jsu_front #(
  parameter int WIDTH = 32
) (
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [WIDTH-1:0]              in_value,
  input  jsu_pkg::mod_t                        modulus,
  input  logic                                 q_full,
  output logic                                 q_wr,
  output logic [jsu_pkg::HDR_W+WIDTH-1:0]      q_wr_data
);

  logic [WIDTH-1:0]   raw;
  logic [WIDTH-1:0]   mag;
  logic               neg;
  jsu_pkg::item_hdr_t hdr;

  assign raw = in_value;
  assign neg = raw[WIDTH-1];
  // most negative value maps to 2^(WIDTH-1), still fits unsigned
  assign mag = neg ? (~raw + WIDTH'(1)) : raw;

  always_comb begin
    hdr.bad     = ~modulus[0];
    hdr.neg     = neg;
    hdr.modulus = modulus;
  end

  assign q_wr_data = {hdr, mag};
  assign q_wr      = in_push & ~q_full;
  assign in_full   = q_full;

endmodule

// ===== sv/jsu_queue.sv =====
// Small flop-based FIFO between front and back end.
module jsu_queue #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              rd,
  output logic [DATA_W-1:0] rd_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr & ~full;
  assign do_rd   = rd & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/jsu_back.sv =====
// Back end: serial residue reduction, binary Jacobi loop, result register.
module jsu_back #(
  parameter int WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  logic [jsu_pkg::HDR_W+WIDTH-1:0] q_rd_data,
  output logic                            q_rd,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic signed [1:0]               out_symbol,
  output logic                            out_bad_modulus
);

  localparam int CNT_W = $clog2(WIDTH);

  jsu_pkg::back_state_t state_r, state_nxt;
  logic [WIDTH-1:0]     div_r, div_nxt;
  jsu_pkg::mod_t        rem_r, rem_nxt;
  jsu_pkg::mod_t        a_r, a_nxt;
  jsu_pkg::mod_t        n_r, n_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 bad_r, bad_nxt;
  logic                 tneg_r, tneg_nxt;
  jsu_pkg::sym_t        sym_r, sym_nxt;
  logic                 out_valid_r, out_valid_nxt;
  jsu_pkg::sym_t        out_sym_r;
  logic                 out_bad_r;
  logic                 out_load;

  jsu_pkg::item_hdr_t          hdr;
  logic [WIDTH-1:0]            mag;
  logic [jsu_pkg::REM_W-1:0]   rem_sh, rem_sub, an_diff;
  jsu_pkg::mod_t               fix_a, na_diff;
  logic                        flip_two, flip_recip;

  assign hdr = jsu_pkg::item_hdr_t'(q_rd_data[jsu_pkg::HDR_W+WIDTH-1:WIDTH]);
  assign mag = q_rd_data[WIDTH-1:0];

  // restoring remainder, one dividend bit per cycle
  assign rem_sh  = {rem_r, div_r[WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, n_r};

  assign fix_a = (neg_r && (rem_r != '0)) ? (n_r - rem_r) : rem_r;

  assign an_diff = {1'b0, a_r} - {1'b0, n_r};
  assign na_diff = n_r - a_r;
  // n odd: n mod 8 is 3 or 5 exactly when bits 2 and 1 differ
  assign flip_two   = n_r[2] ^ n_r[1];
  assign flip_recip = a_r[1] & n_r[1];

  assign out_load = (state_r == jsu_pkg::ST_DONE) && (!out_valid_r || out_pop);

  always_comb begin
    state_nxt = state_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    a_nxt     = a_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    bad_nxt   = bad_r;
    tneg_nxt  = tneg_r;
    sym_nxt   = sym_r;
    q_rd      = 1'b0;
    case (state_r)
      jsu_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_rd    = 1'b1;
          div_nxt = mag;
          rem_nxt = '0;
          cnt_nxt = CNT_W'(WIDTH - 1);
          n_nxt   = hdr.modulus;
          neg_nxt = hdr.neg;
          bad_nxt = hdr.bad;
          if (hdr.bad) begin
            sym_nxt   = jsu_pkg::SYM_ZERO;
            state_nxt = jsu_pkg::ST_DONE;
          end else begin
            state_nxt = jsu_pkg::ST_RED;
          end
        end
      end
      jsu_pkg::ST_RED: begin
        div_nxt = div_r << 1;
        rem_nxt = rem_sub[jsu_pkg::REM_W-1] ? rem_sh[jsu_pkg::MOD_W-1:0]
                                            : rem_sub[jsu_pkg::MOD_W-1:0];
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = jsu_pkg::ST_FIX;
        end
      end
      jsu_pkg::ST_FIX: begin
        a_nxt     = fix_a;
        tneg_nxt  = 1'b0;
        state_nxt = jsu_pkg::ST_LOOP;
      end
      jsu_pkg::ST_LOOP: begin
        if (a_r == '0) begin
          if (n_r == jsu_pkg::mod_t'(1)) begin
            sym_nxt = tneg_r ? jsu_pkg::SYM_NEG : jsu_pkg::SYM_POS;
          end else begin
            sym_nxt = jsu_pkg::SYM_ZERO;
          end
          state_nxt = jsu_pkg::ST_DONE;
        end else if (!a_r[0]) begin
          a_nxt    = a_r >> 1;
          tneg_nxt = tneg_r ^ flip_two;
        end else if (!an_diff[jsu_pkg::MOD_W]) begin
          a_nxt = an_diff[jsu_pkg::MOD_W-1:0];
        end else begin
          // swap, then subtract; reciprocity flip when both are 3 mod 4
          a_nxt    = na_diff;
          n_nxt    = a_r;
          tneg_nxt = tneg_r ^ flip_recip;
        end
      end
      jsu_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = jsu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jsu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_pop;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jsu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    a_r    <= a_nxt;
    n_r    <= n_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    bad_r  <= bad_nxt;
    tneg_r <= tneg_nxt;
    sym_r  <= sym_nxt;
    if (out_load) begin
      out_sym_r <= sym_r;
      out_bad_r <= bad_r;
    end
  end

  assign out_empty       = ~out_valid_r;
  assign out_symbol      = out_sym_r;
  assign out_bad_modulus = out_bad_r;

endmodule

// ===== sv/jacobi_symbol_unit.sv =====
// Top level of the Jacobi symbol unit: modulus register, front, queue, back.
// Flow: the back end takes an item from the queue, reduces it bit-serially, runs the
//   binary Jacobi loop one step a cycle until the value reaches zero, then loads the result.
// The back end finishes one transaction before it takes the next; the queue holds
//   up to two further transactions meanwhile.
// Reset (rst_n low, synchronous): queue and result register empty, back end idle, modulus 3.
module jacobi_symbol_unit #(
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_push,
  output logic                     in_full,
  input  logic signed [WIDTH-1:0]  in_value,
  // result channel
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic signed [1:0]        out_symbol,
  output logic                     out_bad_modulus,
  // configuration channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [30:0]              cfg_modulus
);

  localparam int Q_W = jsu_pkg::HDR_W + WIDTH;

  jsu_pkg::mod_t  mod_r;
  logic           q_wr, q_full, q_rd, q_empty;
  logic [Q_W-1:0] q_wr_data, q_rd_data;

  // Modulus register; writes are only expected while the unit is idle.
  // Each queued transaction carries its own copy of the modulus anyway.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= jsu_pkg::mod_t'(3);
    end else if (cfg_valid && cfg_ready) begin
      mod_r <= cfg_modulus;
    end
  end

  // Front end: sign/magnitude split and even-modulus check, no state.
  jsu_front #(
    .WIDTH (WIDTH)
  ) u_front (
    .in_push   (in_push),
    .in_full   (in_full),
    .in_value  (in_value),
    .modulus   (mod_r),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_data (q_wr_data)
  );

  // Decoupling queue: lets new transactions land while the back end iterates.
  jsu_queue #(
    .DATA_W (Q_W),
    .DEPTH  (jsu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // Back end: reduce into 0..m-1, run the binary Jacobi loop, hold result.
  jsu_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rd_data       (q_rd_data),
    .q_rd            (q_rd),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_symbol      (out_symbol),
    .out_bad_modulus (out_bad_modulus)
  );

endmodule

// ===== sv/jsu_checker.sv =====
// Port-level checks for the Jacobi symbol unit, bound to the top level.
module jsu_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic signed [1:0] out_symbol,
  input logic              out_bad_modulus
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // symbol is one of -1, 0, 1
  a_symbol_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_symbol != 2'sb10)
    else $error("symbol code out of range");

  // even modulus always yields symbol zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_bad_modulus) |-> out_symbol == 2'sb00)
    else $error("nonzero symbol with bad modulus");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_symbol) && $stable(out_bad_modulus)))
    else $error("result changed while waiting");

endmodule

bind jacobi_symbol_unit jsu_checker u_jsu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_symbol      (out_symbol),
  .out_bad_modulus (out_bad_modulus)
);
